### rtl/sensor_frame_crc_decoder_defines.svh
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder: assertion macros
// Shared concurrent assertion forms used by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_DECODER_DEFINES_SVH
`define SENSOR_FRAME_CRC_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder package
// Types, constants and the byte-wide CRC-8 function shared by the decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_CRC = 2'd1,
        ST_HUM_CRC  = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
    } frame_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/sensor_frame_crc_decoder.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder
// Decodes six-byte temperature/humidity frames with CRC-8 checks into scaled
// readings.
//
// Channel   Dir  tdata (low bit up)                                    tuser
// s_axis    in   data_byte[7:0]                                        frame_start
// m_axis    out  status, temperature_centi, humidity_centi,            -
//                raw_temperature, raw_humidity, one zero pad bit
//
// One byte transaction is taken per cycle while the queue has room.
// The queue takes the record at the edge that accepts the sixth byte; from
// there the record passes through the multiply stage and then the output
// register, where the result is valid.
// A stalled output holds the back end; the queue lets the front end run on.
// Reset is asynchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder
    import sfcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_byte
    input  logic        s_axis_tuser,  // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // status, temperature_centi, humidity_centi,
                                       // raw_temperature, raw_humidity, pad
);

    logic        accept, push, pop, empty, full;
    frame_t      entry, head;
    status_t     status;
    logic [14:0] temperature_centi;
    logic [13:0] humidity_centi;
    logic [15:0] raw_temperature, raw_humidity;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sfcd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .push        (push),
        .entry       (entry)
    );

    sfcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .pop       (pop),
        .empty     (empty),
        .full      (full),
        .head      (head)
    );

    sfcd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .empty             (empty),
        .head              (head),
        .pop               (pop),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .status            (status),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .raw_temperature   (raw_temperature),
        .raw_humidity      (raw_humidity)
    );

    assign m_axis_tdata = {1'b0, raw_humidity, raw_temperature, humidity_centi,
                           temperature_centi, status};

endmodule

### rtl/sfcd_front.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder: front end
// Tracks the byte position, runs the CRC and collects the raw words; pushes
// one classified frame record into the queue on the last byte.
// ----------------------------------------------------------------------------
module sfcd_front
    import sfcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    output logic       push,
    output frame_t     entry
);

    logic [2:0]  pos_reg, pos_next, pos_cur;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] hum_word_reg, hum_word_next;
    logic        temp_ok_reg, temp_ok_next;

    always_comb
    begin
        pos_cur = pos_reg;
        if (frame_start || pos_reg > POS_H_CRC)
        begin
            pos_cur = POS_T_MSB;
        end
    end

    always_comb
    begin
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        temp_ok_next   = temp_ok_reg;
        case (pos_cur)
            POS_T_MSB:
            begin
                temp_word_next = {data_byte, temp_word_reg[7:0]};
                crc_next       = crc8_byte(CRC_INIT, data_byte);
            end
            POS_T_LSB:
            begin
                temp_word_next = {temp_word_reg[15:8], data_byte};
                crc_next       = crc8_byte(crc_reg, data_byte);
            end
            POS_T_CRC:
            begin
                temp_ok_next = (crc_reg == data_byte);
                crc_next     = CRC_INIT;
            end
            POS_H_MSB:
            begin
                hum_word_next = {data_byte, hum_word_reg[7:0]};
                crc_next      = crc8_byte(CRC_INIT, data_byte);
            end
            POS_H_LSB:
            begin
                hum_word_next = {hum_word_reg[15:8], data_byte};
                crc_next      = crc8_byte(crc_reg, data_byte);
            end
            default:
            begin
                crc_next = CRC_INIT;
            end
        endcase
        pos_next = (pos_cur >= POS_H_CRC) ? POS_T_MSB : pos_cur + 3'd1;
    end

    always_comb
    begin
        push                  = accept && (pos_cur == POS_H_CRC);
        entry.raw_temperature = temp_word_reg;
        entry.raw_humidity    = hum_word_reg;
        if (!temp_ok_reg)
        begin
            entry.status = ST_TEMP_CRC;
        end
        else if (crc_reg != data_byte)
        begin
            entry.status = ST_HUM_CRC;
        end
        else
        begin
            entry.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_MSB;
            crc_reg       <= CRC_INIT;
            temp_word_reg <= '0;
            hum_word_reg  <= '0;
            temp_ok_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            hum_word_reg  <= hum_word_next;
            temp_ok_reg   <= temp_ok_next;
        end
    end

endmodule

### rtl/sfcd_queue.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder: frame queue
// Small FIFO of frame records between the front end and the back end.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_decoder_defines.svh"

module sfcd_queue
    import sfcd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_data,
    input  logic   pop,
    output logic   empty,
    output logic   full,
    output frame_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    frame_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_COUNT);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    `SFCD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_COUNT, "queue overfilled")
    `SFCD_ASSERT_NXT(a_count_up, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + CW'(1), "queue count did not grow")
    `SFCD_ASSERT_NXT(a_count_down, clk, rst_n, do_pop && !do_push, count_reg == $past(count_reg) - CW'(1), "queue count did not shrink")

endmodule

### rtl/sfcd_back.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder: back end
// Scales the raw words in two stages (constant multiply, then divide by the
// full-scale value with a single correction) and holds the result for output.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_decoder_defines.svh"

module sfcd_back
    import sfcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  frame_t      head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output status_t     status,
    output logic [14:0] temperature_centi,
    output logic [13:0] humidity_centi,
    output logic [15:0] raw_temperature,
    output logic [15:0] raw_humidity
);

    logic        s1_valid_reg;
    frame_t      s1_frame_reg;
    logic [30:0] s1_temp_prod_reg;
    logic [29:0] s1_hum_prod_reg;

    logic        out_valid_reg;
    frame_t      out_frame_reg;
    logic [14:0] out_temp_reg, out_temp_next;
    logic [13:0] out_hum_reg, out_hum_next;

    logic        adv_out, adv_s1;
    logic [16:0] temp_sum, hum_sum;
    logic [14:0] temp_q;
    logic [13:0] hum_q;
    logic [15:0] temp_signed;

    assign adv_out = !out_valid_reg || out_ready;
    assign adv_s1  = !s1_valid_reg || adv_out;
    assign pop     = !empty && adv_s1;

    always_comb
    begin
        temp_sum    = {2'b0, s1_temp_prod_reg[30:16]} + {1'b0, s1_temp_prod_reg[15:0]};
        hum_sum     = {3'b0, s1_hum_prod_reg[29:16]} + {1'b0, s1_hum_prod_reg[15:0]};
        temp_q      = s1_temp_prod_reg[30:16] + 15'(temp_sum >= FULL_SCALE);
        hum_q       = s1_hum_prod_reg[29:16] + 14'(hum_sum >= FULL_SCALE);
        temp_signed = {1'b0, temp_q} - TEMP_OFFSET;
        if (s1_frame_reg.status == ST_OK)
        begin
            out_temp_next = temp_signed[14:0];
            out_hum_next  = hum_q;
        end
        else
        begin
            out_temp_next = '0;
            out_hum_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            s1_frame_reg     <= head;
            s1_temp_prod_reg <= TEMP_SCALE * head.raw_temperature;
            s1_hum_prod_reg  <= HUM_SCALE * head.raw_humidity;
        end
        if (adv_out)
        begin
            out_frame_reg <= s1_frame_reg;
            out_temp_reg  <= out_temp_next;
            out_hum_reg   <= out_hum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
            begin
                s1_valid_reg <= !empty;
            end
            if (adv_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_frame_reg.status;
    assign temperature_centi = out_temp_reg;
    assign humidity_centi    = out_hum_reg;
    assign raw_temperature   = out_frame_reg.raw_temperature;
    assign raw_humidity      = out_frame_reg.raw_humidity;

    `SFCD_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid_reg && out_frame_reg.status != ST_OK, out_temp_reg == '0 && out_hum_reg == '0, "error result carries nonzero values")
    `SFCD_ASSERT_IMP(a_hum_range, clk, rst_n, out_valid_reg, out_hum_reg <= 14'd10000, "humidity above full scale")
    `SFCD_ASSERT_NXT(a_s1_hold, clk, rst_n, s1_valid_reg && !adv_out, s1_valid_reg, "stage one lost a record while stalled")

endmodule
